/* rtl/core/npt_pkg.sv */
package npt_pkg;

   localparam int MAX_NODES    = 32;
   localparam int SAMPLE_LIMIT = 255;
   localparam int IDX_W        = $clog2(MAX_NODES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int DIV_STEPS    = 16;

   localparam logic [5:0]  DETECT_RESET  = 6'd15;
   localparam logic [5:0]  ABSENT_RESET  = 6'd30;
   localparam logic [7:0]  INDOOR_RESET  = 8'hA7;
   localparam logic [7:0]  OUTDOOR_RESET = 8'hAF;
   localparam logic [16:0] LUX_RESET     = 17'd1200;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_CYCLE  = 1'b1;

   typedef enum logic [2:0] {
      REG_DETECT  = 3'd0,
      REG_ABSENT  = 3'd1,
      REG_INDOOR  = 3'd2,
      REG_OUTDOOR = 3'd3,
      REG_LUX     = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      RES_DONE   = 2'd0,
      RES_DETECT = 2'd1,
      RES_ABSENT = 2'd2
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PACKET,
      ST_SCAN,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic              op;
      logic [IDX_W-1:0]  node;
      logic signed [7:0] rssi;
      logic [31:0]       start;
      logic              outdoor;
   } item_type;

   typedef struct packed {
      logic [5:0]        need_detect;
      logic [5:0]        need_absent;
      logic signed [7:0] thr_indoor;
      logic signed [7:0] thr_outdoor;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      res_type     res;
      logic [4:0]  node;
      logic [31:0] time_s;
      logic        last;
   } rsp_type;

endpackage

/* rtl/core/neighbour_presence_tracker_core.sv */
// packet request: written into the queue, popped in ST_IDLE and applied in ST_PACKET, one read-modify-write
// cycle request: ST_SCAN skips free entries; a live entry passes ST_SCAN, the 16-step divider in ST_DIV
// (skipped when it holds no samples) and ST_UPDATE; ST_DONE then sends the done record
// a two-deep queue takes requests while the back end walks; busy rises only when it is full
// results are one-cycle strobes, the receiver cannot stall
// synchronous reset empties the queue, frees all entries and restores register defaults
module neighbour_presence_tracker_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [4:0]        req_node_id,
   input  logic signed [7:0] req_rssi,
   input  logic [31:0]       req_cycle_start_s,
   input  logic [16:0]       req_light_lux,
   input  logic              req_light_error,
   output logic              rsp_valid,
   output logic [1:0]        rsp_event_res,
   output logic [4:0]        rsp_event_node,
   output logic [31:0]       rsp_event_time_s,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import npt_pkg::*;

   logic [5:0]  detect_ff, absent_ff;
   logic [7:0]  indoor_ff, outdoor_ff;
   logic [16:0] lux_ff;
   logic        wr_en, pop, head_valid;
   item_type    head;
   cfg_type     cfg;
   rsp_type     rsp;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_ff  <= DETECT_RESET;
         absent_ff  <= ABSENT_RESET;
         indoor_ff  <= INDOOR_RESET;
         outdoor_ff <= OUTDOOR_RESET;
         lux_ff     <= LUX_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_DETECT:  detect_ff  <= pwdata[5:0];
            REG_ABSENT:  absent_ff  <= pwdata[5:0];
            REG_INDOOR:  indoor_ff  <= pwdata[7:0];
            REG_OUTDOOR: outdoor_ff <= pwdata[7:0];
            REG_LUX:     lux_ff     <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DETECT:  prdata = {26'd0, detect_ff};
         REG_ABSENT:  prdata = {26'd0, absent_ff};
         REG_INDOOR:  prdata = {{24{indoor_ff[7]}}, indoor_ff};
         REG_OUTDOOR: prdata = {{24{outdoor_ff[7]}}, outdoor_ff};
         REG_LUX:     prdata = {15'd0, lux_ff};
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      cfg.need_detect = (detect_ff < 6'd2) ? 6'd2 : detect_ff;
      cfg.need_absent = (absent_ff < 6'd2) ? 6'd2 : absent_ff;
      cfg.thr_indoor  = indoor_ff;
      cfg.thr_outdoor = outdoor_ff;
   end

   npt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_node_id       (req_node_id),
      .req_rssi          (req_rssi),
      .req_cycle_start_s (req_cycle_start_s),
      .req_light_lux     (req_light_lux),
      .req_light_error   (req_light_error),
      .outdoor_lux       (lux_ff),
      .pop               (pop),
      .head_valid        (head_valid),
      .head              (head)
   );

   npt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_event_res    = rsp.res;
   assign rsp_event_node   = rsp.node;
   assign rsp_event_time_s = rsp.time_s;
   assign rsp_last         = rsp.last;

endmodule

/* rtl/core/npt_front.sv */
module npt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [4:0]        req_node_id,
   input  logic signed [7:0] req_rssi,
   input  logic [31:0]       req_cycle_start_s,
   input  logic [16:0]       req_light_lux,
   input  logic              req_light_error,
   input  logic [16:0]       outdoor_lux,
   input  logic              pop,
   output logic              head_valid,
   output npt_pkg::item_type head
);
   import npt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;
   logic                accept, keep, do_pop;
   item_type            item;

   assign busy   = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign accept = start && !busy;
   assign keep   = accept && ((req_op == OP_CYCLE) ||
                   ({1'b0, req_node_id} < 6'(MAX_NODES)));
   assign do_pop = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      item.op      = req_op;
      item.node    = req_node_id[IDX_W-1:0];
      item.rssi    = req_rssi;
      item.start   = req_cycle_start_s;
      item.outdoor = !req_light_error && (req_light_lux >= outdoor_lux);
   end

   always_comb begin
      wr_ptr_in = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(keep) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* rtl/core/npt_back.sv */
module npt_back (
   input  logic              clock,
   input  logic              reset,
   input  npt_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  npt_pkg::item_type head,
   output logic              pop,
   output npt_pkg::rsp_type  rsp
);
   import npt_pkg::*;

   back_state_type state_ff, state_in;

   logic [MAX_NODES-1:0] valid_ff;
   logic                 near_ff    [MAX_NODES];
   logic [5:0]           run_ff     [MAX_NODES];
   logic signed [15:0]   total_ff   [MAX_NODES];
   logic [7:0]           samples_ff [MAX_NODES];
   logic [31:0]          det_ts_ff  [MAX_NODES];
   logic [31:0]          abs_ts_ff  [MAX_NODES];

   item_type         cur_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      quo_ff, quo_in;
   logic [8:0]       rem_ff, rem_in;
   logic [7:0]       den_ff;
   logic             neg_ff, has_ff;
   logic [4:0]       step_ff, step_in;
   rsp_type          rsp_ff, rsp_in;

   logic [8:0]         trial;
   logic signed [16:0] avg, thr;
   logic               near_cycle, st_new, upd_done;
   logic [5:0]         cons_new;
   logic               emit;
   res_type            emit_res;
   logic [31:0]        emit_ts;
   logic               last_idx;

   assign pop      = (state_ff == ST_IDLE) && head_valid;
   assign last_idx = (idx_ff == IDX_W'(MAX_NODES-1));
   assign rsp      = rsp_ff;

   always_comb begin
      trial  = {rem_ff[7:0], quo_ff[15]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (trial >= {1'b0, den_ff}) begin
         rem_in = trial - {1'b0, den_ff};
         quo_in = {quo_ff[14:0], 1'b1};
      end else begin
         rem_in = trial;
         quo_in = {quo_ff[14:0], 1'b0};
      end
   end

   always_comb begin
      avg = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      thr = cur_ff.outdoor ? 17'(cfg.thr_outdoor) : 17'(cfg.thr_indoor);
      near_cycle = has_ff && (avg >= thr);
      cons_new = run_ff[idx_ff];
      st_new   = near_ff[idx_ff];
      emit     = 1'b0;
      emit_res = RES_DONE;
      emit_ts  = '0;
      upd_done = 1'b0;
      if (near_ff[idx_ff] && !near_cycle) begin
         cons_new = run_ff[idx_ff] + 6'd1;
         emit_ts  = abs_ts_ff[idx_ff];
         if (cons_new != 6'd1 && cons_new >= cfg.need_absent) begin
            cons_new = '0;
            st_new   = 1'b0;
            emit     = 1'b1;
            emit_res = RES_ABSENT;
         end
      end else if (!near_ff[idx_ff] && near_cycle) begin
         cons_new = run_ff[idx_ff] + 6'd1;
         emit_ts  = det_ts_ff[idx_ff];
         if (cons_new != 6'd1 && cons_new >= cfg.need_detect) begin
            cons_new = '0;
            st_new   = 1'b1;
            emit     = 1'b1;
            emit_res = RES_DETECT;
         end
      end else begin
         cons_new = '0;
      end
      upd_done = (cons_new == '0) && !st_new && !near_cycle;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = (head.op == OP_CYCLE) ? ST_SCAN : ST_PACKET;
            end
         end
         ST_PACKET: state_in = ST_IDLE;
         ST_SCAN: begin
            if (valid_ff[idx_ff]) begin
               state_in = (samples_ff[idx_ff] != '0) ? ST_DIV : ST_UPDATE;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (step_ff == 5'(DIV_STEPS-1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = last_idx ? ST_DONE : ST_SCAN;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in  = idx_ff;
      step_in = step_ff;
      rsp_in  = '0;
      unique case (state_ff)
         ST_IDLE: idx_in = '0;
         ST_SCAN: begin
            step_in = '0;
            if (!valid_ff[idx_ff]) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV: step_in = step_ff + 5'd1;
         ST_UPDATE: begin
            idx_in = idx_ff + 1'b1;
            if (emit) begin
               rsp_in.valid  = 1'b1;
               rsp_in.res    = emit_res;
               rsp_in.node   = 5'(idx_ff);
               rsp_in.time_s = emit_ts;
            end
         end
         ST_DONE: begin
            rsp_in.valid  = 1'b1;
            rsp_in.res    = RES_DONE;
            rsp_in.time_s = cur_ff.start;
            rsp_in.last   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         if (state_ff == ST_PACKET) begin
            valid_ff[cur_ff.node] <= 1'b1;
         end else if (state_ff == ST_UPDATE && upd_done) begin
            valid_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      step_ff <= step_in;
      if (pop) begin
         cur_ff <= head;
      end
      unique case (state_ff)
         ST_PACKET: begin
            if (!valid_ff[cur_ff.node]) begin
               near_ff[cur_ff.node]    <= 1'b0;
               run_ff[cur_ff.node]     <= '0;
               total_ff[cur_ff.node]   <= 16'(cur_ff.rssi);
               samples_ff[cur_ff.node] <= 8'd1;
            end else if (samples_ff[cur_ff.node] < 8'(SAMPLE_LIMIT)) begin
               total_ff[cur_ff.node]   <= total_ff[cur_ff.node] + 16'(cur_ff.rssi);
               samples_ff[cur_ff.node] <= samples_ff[cur_ff.node] + 8'd1;
            end
         end
         ST_SCAN: begin
            has_ff <= (samples_ff[idx_ff] != '0);
            neg_ff <= total_ff[idx_ff][15];
            den_ff <= samples_ff[idx_ff];
            rem_ff <= '0;
            quo_ff <= total_ff[idx_ff][15] ? 16'(-total_ff[idx_ff])
                                           : 16'(total_ff[idx_ff]);
         end
         ST_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end
         ST_UPDATE: begin
            run_ff[idx_ff]     <= cons_new;
            near_ff[idx_ff]    <= st_new;
            total_ff[idx_ff]   <= '0;
            samples_ff[idx_ff] <= '0;
            if (cons_new == 6'd1 && near_ff[idx_ff]) begin
               abs_ts_ff[idx_ff] <= cur_ff.start;
            end
            if (cons_new == 6'd1 && !near_ff[idx_ff]) begin
               det_ts_ff[idx_ff] <= cur_ff.start;
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/npt_checker.sv */
module npt_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_event_res,
   input logic [4:0] rsp_event_node,
   input logic       rsp_last
);
   import npt_pkg::*;

   assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or result right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res == RES_DONE) || (rsp_event_res == RES_DETECT) ||
                    (rsp_event_res == RES_ABSENT))
      else $error("bad result code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_event_res == RES_DONE)))
      else $error("last not tied to done record");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_event_node == '0)
      else $error("done record with non-zero node");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result straight after done record");

endmodule

bind neighbour_presence_tracker_core npt_checker u_npt_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_event_res  (rsp_event_res),
   .rsp_event_node (rsp_event_node),
   .rsp_last       (rsp_last)
);

/* tb/sv/tb_neighbour_presence_tracker_core.sv */
`timescale 1ns / 100ps

module tb_neighbour_presence_tracker_core;
   import npt_pkg::*;

   localparam int  DRAIN_CYCLES = 640;
   localparam longint CYCLE_LIMIT = 600000;

   typedef struct {
      logic [1:0]  res;
      logic [4:0]  node;
      logic [31:0] time_s;
      logic        last;
   } presence_event_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [4:0]        req_node_id;
   logic signed [7:0] req_rssi;
   logic [31:0]       req_cycle_start_s;
   logic [16:0]       req_light_lux;
   logic              req_light_error;
   logic              rsp_valid;
   logic [1:0]        rsp_event_res;
   logic [4:0]        rsp_event_node;
   logic [31:0]       rsp_event_time_s;
   logic              rsp_last;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [4:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // tracker state as predicted
   logic [5:0]         cfg_detect;
   logic [5:0]         cfg_absent;
   logic signed [7:0]  cfg_indoor;
   logic signed [7:0]  cfg_outdoor;
   logic [16:0]        cfg_lux;
   logic               nb_valid [MAX_NODES];
   logic               nb_near [MAX_NODES];
   logic [5:0]         nb_run [MAX_NODES];
   logic signed [15:0] nb_total [MAX_NODES];
   logic [7:0]         nb_samples [MAX_NODES];
   logic [31:0]        nb_detect_since [MAX_NODES];
   logic [31:0]        nb_absent_since [MAX_NODES];

   presence_event_type pending_events[$];
   int     err_count;
   int     burst_left;
   longint cycle_count;
   logic [31:0] cycle_time;

   neighbour_presence_tracker_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic clear_tracker();
      cfg_detect  = DETECT_RESET;
      cfg_absent  = ABSENT_RESET;
      cfg_indoor  = INDOOR_RESET;
      cfg_outdoor = OUTDOOR_RESET;
      cfg_lux     = LUX_RESET;
      for (int i = 0; i < MAX_NODES; i++) begin
         nb_valid[i] = 1'b0;
         nb_near[i] = 1'b0;
         nb_run[i] = '0;
         nb_total[i] = '0;
         nb_samples[i] = '0;
         nb_detect_since[i] = '0;
         nb_absent_since[i] = '0;
      end
   endtask

   task automatic track_packet(logic [4:0] node, logic signed [7:0] rssi);
      if (!nb_valid[node]) begin
         nb_valid[node] = 1'b1;
         nb_near[node] = 1'b0;
         nb_run[node] = '0;
         nb_total[node] = '0;
         nb_samples[node] = '0;
      end
      if (nb_samples[node] < SAMPLE_LIMIT) begin
         nb_total[node] = nb_total[node] + rssi;
         nb_samples[node] = nb_samples[node] + 8'd1;
      end
   endtask

   task automatic close_cycle(logic [31:0] t0, logic [16:0] lux, logic lerr);
      logic              outdoor;
      logic signed [7:0] thr;
      int                need_det;
      int                need_abs;
      int                avg;
      int                run;
      logic              near_now;
      logic              st;
      presence_event_type ev;
      outdoor  = !lerr && (lux >= cfg_lux);
      thr      = outdoor ? cfg_outdoor : cfg_indoor;
      need_det = (cfg_detect < 2) ? 2 : cfg_detect;
      need_abs = (cfg_absent < 2) ? 2 : cfg_absent;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (nb_valid[i]) begin
            near_now = 1'b0;
            if (nb_samples[i] != 0) begin
               avg = int'(nb_total[i]) / int'(nb_samples[i]);
               near_now = (avg >= int'(thr));
            end
            st  = nb_near[i];
            run = nb_run[i];
            if (st && !near_now) begin
               run++;
               if (run == 1) nb_absent_since[i] = t0;
               else if (run >= need_abs) begin
                  run = 0;
                  st = 1'b0;
                  ev.res = RES_ABSENT; ev.node = 5'(i); ev.time_s = nb_absent_since[i];
                  ev.last = 1'b0;
                  pending_events.push_back(ev);
               end
            end else if (!st && near_now) begin
               run++;
               if (run == 1) nb_detect_since[i] = t0;
               else if (run >= need_det) begin
                  run = 0;
                  st = 1'b1;
                  ev.res = RES_DETECT; ev.node = 5'(i); ev.time_s = nb_detect_since[i];
                  ev.last = 1'b0;
                  pending_events.push_back(ev);
               end
            end else begin
               run = 0;
            end
            if (run == 0 && !st && !near_now) nb_valid[i] = 1'b0;
            nb_run[i] = run[5:0];
            nb_near[i] = st;
            nb_total[i] = '0;
            nb_samples[i] = '0;
         end
      end
      ev.res = RES_DONE; ev.node = '0; ev.time_s = t0; ev.last = 1'b1;
      pending_events.push_back(ev);
   endtask

   // request acceptance
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (req_op == OP_PACKET) track_packet(req_node_id, req_rssi);
         else close_cycle(req_cycle_start_s, req_light_lux, req_light_error);
      end
   end

   // result checking
   always @(posedge clock) begin
      presence_event_type ev;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result res=%0d node=%0d", rsp_event_res, rsp_event_node);
            err_count++;
         end else begin
            ev = pending_events.pop_front();
            if (rsp_event_res !== ev.res) begin
               $error("event_res expected %0d actual %0d", ev.res, rsp_event_res);
               err_count++;
            end
            if (rsp_event_node !== ev.node) begin
               $error("event_node expected %0d actual %0d", ev.node, rsp_event_node);
               err_count++;
            end
            if (rsp_event_time_s !== ev.time_s) begin
               $error("event_time_s expected %0h actual %0h", ev.time_s, rsp_event_time_s);
               err_count++;
            end
            if (rsp_last !== ev.last) begin
               $error("last expected %0d actual %0d", ev.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_request(logic op, logic [4:0] node, logic signed [7:0] rssi,
                               logic [31:0] t0, logic [16:0] lux, logic lerr);
      start             <= 1'b1;
      req_op            <= op;
      req_node_id       <= node;
      req_rssi          <= rssi;
      req_cycle_start_s <= t0;
      req_light_lux     <= lux;
      req_light_error   <= lerr;
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end
   endtask

   task automatic send_packet(logic [4:0] node, logic signed [7:0] rssi);
      send_request(OP_PACKET, node, rssi, $urandom, 17'($urandom_range(0, 83865)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic send_cycle(logic [16:0] lux, logic lerr);
      cycle_time = cycle_time + $urandom_range(1, 1000);
      send_request(OP_CYCLE, 5'($urandom), 8'($urandom), cycle_time, lux, lerr);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_DETECT:  cfg_detect = value[5:0];
         REG_ABSENT:  cfg_absent = value[5:0];
         REG_INDOOR:  cfg_indoor = value[7:0];
         REG_OUTDOOR: cfg_outdoor = value[7:0];
         REG_LUX:     cfg_lux = value[16:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [5:0] det, logic [5:0] abs_n, logic signed [7:0] ind,
                            logic signed [7:0] outd, logic [16:0] lux);
      csr_write(REG_DETECT, 32'(det));
      csr_write(REG_ABSENT, 32'(abs_n));
      csr_write(REG_INDOOR, {24'h0, ind});
      csr_write(REG_OUTDOOR, {24'h0, outd});
      csr_write(REG_LUX, 32'(lux));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic test_directed();
      // field extremes at reset settings
      send_packet(5'd0, 8'sd127);
      send_packet(5'd31, -8'sd128);
      send_packet(5'd10, 8'sd0);
      cycle_time = 32'hFFFF_F000;
      send_cycle(17'd83865, 1'b1);
      send_cycle(17'd0, 1'b0);
      wait_drained();
      // smallest counts: detect after two near cycles, absent after two far
      configure(6'd0, 6'd1, -8'sd60, 8'sd20, 17'd83865);
      for (int c = 0; c < 2; c++) begin
         send_packet(5'd7, -8'sd60);
         send_packet(5'd7, -8'sd61);
         send_packet(5'd7, -8'sd59);
         send_packet(5'd3, -8'sd90);
         send_cycle(17'd5, 1'b0);
      end
      send_packet(5'd7, 8'sd10);
      send_cycle(17'd83865, 1'b0);
      send_cycle(17'd0, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_phase(int cycles);
      logic [31:0]       live;
      int                thr;
      int                val;
      logic [4:0]        nd;
      logic [16:0]       lux;
      logic              lerr;
      live = $urandom & $urandom & $urandom;
      for (int c = 0; c < cycles; c++) begin
         lerr = ($urandom_range(0, 5) == 0);
         lux  = ($urandom_range(0, 1) == 1) ? cfg_lux : 17'($urandom_range(0, 83865));
         thr  = (!lerr && lux >= cfg_lux) ? int'(cfg_outdoor) : int'(cfg_indoor);
         for (int n = 0; n < MAX_NODES; n++) begin
            if (live[n] && $urandom_range(0, 5) != 0) begin
               repeat ($urandom_range(1, 3)) begin
                  val = thr + $urandom_range(0, 6) - 2;
                  if (!nb_near[n] && $urandom_range(0, 3) == 0) val = thr - 20;
                  if (val > 127) val = 127;
                  if (val < -128) val = -128;
                  send_packet(n[4:0], val[7:0]);
               end
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            nd = 5'($urandom);
            send_packet(nd, 8'($urandom));
         end
         send_cycle(lux, lerr);
         if ($urandom_range(0, 3) == 0) live = live ^ (32'd1 << $urandom_range(0, 31));
      end
      wait_drained();
   endtask

   task automatic test_random();
      configure(6'd2, 6'd3, -8'sd70, -8'sd78, 17'd1200);
      test_random_phase(4);
      configure(6'd63, 6'd63, -8'sd128, 8'sd127, 17'd0);
      test_random_phase(3);
      configure(6'd3, 6'd2, 8'sd127, -8'sd128, 17'd83865);
      test_random_phase(4);
      configure(6'($urandom_range(2, 4)), 6'($urandom_range(2, 4)), 8'($urandom),
                8'($urandom), 17'($urandom_range(0, 83865)));
      test_random_phase(3);
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_op            = OP_PACKET;
      req_node_id       = '0;
      req_rssi          = '0;
      req_cycle_start_s = '0;
      req_light_lux     = '0;
      req_light_error   = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      err_count         = 0;
      burst_left        = 0;
      cycle_count       = 0;
      cycle_time        = $urandom;
      clear_tracker();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      test_directed();
      test_random();
      wait_drained();
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* neighbour_presence_tracker_core.f */
rtl/core/npt_pkg.sv
rtl/core/npt_front.sv
rtl/core/npt_back.sv
rtl/core/neighbour_presence_tracker_core.sv
rtl/core/npt_checker.sv
tb/sv/tb_neighbour_presence_tracker_core.sv
